// ===== hw/rtl/fmd_pkg.sv =====
// ----------------------------------------------------------------------------
// fmd_pkg
// Shared constants and types for the cross-product FM discriminator.
// ----------------------------------------------------------------------------
package fmd_pkg;

   // default sample width
   localparam int SAMPLE_WIDTH_DEF = 16;

   // output level width and fixed levels
   localparam int           LEVEL_W   = 8;
   localparam logic [7:0]   MID_LEVEL = 8'd127;
   localparam logic [7:0]   MAX_LEVEL = 8'd255;

   // quotient bits resolved by the divider, plus one overrange test step
   localparam int           QUOT_W    = LEVEL_W;
   localparam int           DIV_STEPS = QUOT_W + 1;
   localparam int           DIV_CNT_W = $clog2(DIV_STEPS);

   // divider status handed back to the sequencer
   typedef struct packed {
      logic done;
      logic clip;
   } fmd_div_status_type;

endpackage

// ===== hw/rtl/iq_cross_product_fm_demod.sv =====
// ----------------------------------------------------------------------------
// iq_cross_product_fm_demod
// One word is in flight at a time: a new word is taken only after the last
// result is loaded into the output register, which waits while results are
// stalled. Each word takes four passes through the shared multiplier, four
// scaling steps and the nine-step bit-serial divider; a zero-magnitude sample
// ends after the first scaling step, and a clipping level after one divide step.
// Reset (synchronous) clears the sequencer, the output valid and the stored
// previous sample to zero.
// ----------------------------------------------------------------------------
module iq_cross_product_fm_demod
   import fmd_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_real,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_imag,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [LEVEL_W-1:0]             rsp_audio_level,
   output logic                           rsp_zero_magnitude,
   output logic                           rsp_clipped
);

   localparam int PW  = 2 * SAMPLE_WIDTH;
   localparam int NW  = PW + 8;
   localparam int DW  = PW + 1;

   // sequencer codes
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_M0   = 4'd1;
   localparam logic [3:0] S_M1   = 4'd2;
   localparam logic [3:0] S_M2   = 4'd3;
   localparam logic [3:0] S_M3   = 4'd4;
   localparam logic [3:0] S_M4   = 4'd5;
   localparam logic [3:0] S_SUM  = 4'd6;
   localparam logic [3:0] S_ABS  = 4'd7;
   localparam logic [3:0] S_SCL  = 4'd8;
   localparam logic [3:0] S_NUM  = 4'd9;
   localparam logic [3:0] S_DST  = 4'd10;
   localparam logic [3:0] S_DIV  = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   logic [3:0]                     state_ff, state_in;
   logic signed [SAMPLE_WIDTH-1:0] cur_re_ff, cur_im_ff;
   logic signed [SAMPLE_WIDTH-1:0] prv_re_ff, prv_im_ff;
   logic signed [PW:0]             cross_ff;
   logic [PW-1:0]                  mag_ff;
   logic signed [PW+1:0]           sum_ff;
   logic [PW:0]                    abs_ff;
   logic [NW-1:0]                  num_ff;
   logic [LEVEL_W-1:0]             lvl_ff;
   logic                           zero_ff, clip_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]             rsp_lvl_ff;
   logic                           rsp_zero_ff, rsp_clip_ff;

   logic                           accept;
   logic                           out_free;
   logic                           mul_en;
   logic signed [SAMPLE_WIDTH-1:0] mul_a, mul_b;
   logic signed [PW-1:0]           prod;
   logic [PW+1:0]                  neg_sum;
   logic [PW+8:0]                  scl_wide;
   fmd_div_status_type             div_status;
   logic [QUOT_W-1:0]              div_quot;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // select multiplier operands for each pass
   always_comb begin
      mul_en = 1'b1;
      mul_a  = cur_im_ff;
      mul_b  = prv_re_ff;
      unique case (state_ff)
         S_M0: begin
            mul_a = cur_im_ff;
            mul_b = prv_re_ff;
         end
         S_M1: begin
            mul_a = cur_re_ff;
            mul_b = prv_im_ff;
         end
         S_M2: begin
            mul_a = cur_re_ff;
            mul_b = cur_re_ff;
         end
         S_M3: begin
            mul_a = cur_im_ff;
            mul_b = cur_im_ff;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   fmd_mul #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_mul (
      .clock    (clock),
      .mul_en   (mul_en),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (prod)
   );

   fmd_div #(
      .NUM_W (NW),
      .DEN_W (DW)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .div_start  (state_ff == S_DST),
      .div_num    (num_ff),
      .div_den    ({mag_ff, 1'b0}),
      .div_status (div_status),
      .div_quot   (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_M0;
         S_M0:   state_in = S_M1;
         S_M1:   state_in = S_M2;
         S_M2:   state_in = S_M3;
         S_M3:   state_in = S_M4;
         S_M4:   state_in = S_SUM;
         S_SUM:  state_in = (mag_ff == '0) ? S_DONE : S_ABS;
         S_ABS:  state_in = S_SCL;
         S_SCL:  state_in = S_NUM;
         S_NUM:  state_in = S_DST;
         S_DST:  state_in = S_DIV;
         S_DIV:  if (div_status.done) state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // output valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control state and stored sample
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_re_ff    <= '0;
         cur_im_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            cur_re_ff <= req_sample_real;
            cur_im_ff <= req_sample_imag;
         end
      end
   end

   // scaling arithmetic
   assign neg_sum  = ~sum_ff + 1'b1;
   assign scl_wide = {abs_ff, 8'b0} - {7'b0, abs_ff, 1'b0};

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         prv_re_ff <= cur_re_ff;
         prv_im_ff <= cur_im_ff;
      end
      unique case (state_ff)
         S_M1:  cross_ff <= {prod[PW-1], prod};
         S_M2:  cross_ff <= cross_ff - {prod[PW-1], prod};
         S_M3:  mag_ff   <= prod;
         S_M4:  mag_ff   <= mag_ff + prod;
         S_SUM: begin
            sum_ff  <= {cross_ff[PW], cross_ff} + {2'b00, mag_ff};
            lvl_ff  <= MID_LEVEL;
            zero_ff <= 1'b1;
            clip_ff <= 1'b0;
         end
         S_ABS: abs_ff <= sum_ff[PW+1] ? neg_sum[PW:0] : sum_ff[PW:0];
         S_SCL: num_ff <= scl_wide[NW-1:0];
         S_NUM: num_ff <= num_ff + NW'(mag_ff);
         S_DIV: begin
            if (div_status.done) begin
               lvl_ff  <= div_status.clip ? MAX_LEVEL : div_quot;
               zero_ff <= 1'b0;
               clip_ff <= div_status.clip;
            end
         end
         default: begin
         end
      endcase
      // load the output word
      if (state_ff == S_DONE && out_free) begin
         rsp_lvl_ff  <= lvl_ff;
         rsp_zero_ff <= zero_ff;
         rsp_clip_ff <= clip_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_audio_level    = rsp_lvl_ff;
   assign rsp_zero_magnitude = rsp_zero_ff;
   assign rsp_clipped        = rsp_clip_ff;

endmodule

// ===== hw/rtl/fmd_mul.sv =====
// ----------------------------------------------------------------------------
// fmd_mul
// Shared signed multiplier with a registered product. Used once per cycle,
// in the multiply states of the sequencer, for the cross and magnitude terms.
// ----------------------------------------------------------------------------
module fmd_mul
   import fmd_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             mul_en,
   input  logic signed [SAMPLE_WIDTH-1:0]   mul_a,
   input  logic signed [SAMPLE_WIDTH-1:0]   mul_b,
   output logic signed [2*SAMPLE_WIDTH-1:0] mul_prod
);

   logic signed [2*SAMPLE_WIDTH-1:0] prod_ff;
   logic signed [2*SAMPLE_WIDTH-1:0] prod_in;

   // form the full-width product
   assign prod_in = mul_a * mul_b;

   // hold the product until the next issue
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign mul_prod = prod_ff;

endmodule

// ===== hw/rtl/fmd_div.sv =====
// ----------------------------------------------------------------------------
// fmd_div
// Restoring divider, one quotient bit per cycle. The first step tests the
// numerator against 256 times the divisor and flags overrange; otherwise
// eight further steps resolve an 8-bit quotient.
// ----------------------------------------------------------------------------
module fmd_div
   import fmd_pkg::*;
#(
   parameter int NUM_W = 40,
   parameter int DEN_W = 33
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       div_start,
   input  logic [NUM_W-1:0]           div_num,
   input  logic [DEN_W-1:0]           div_den,
   output fmd_div_status_type         div_status,
   output logic [QUOT_W-1:0]          div_quot
);

   localparam int DSR_W = DEN_W + QUOT_W;

   logic                 active_ff, active_in;
   logic                 done_ff,   done_in;
   logic                 clip_ff,   clip_in;
   logic [DIV_CNT_W-1:0] cnt_ff,    cnt_in;
   logic [NUM_W-1:0]     rem_ff,    rem_in;
   logic [DSR_W-1:0]     dsr_ff,    dsr_in;
   logic [QUOT_W-1:0]    quot_ff,   quot_in;

   logic                 ge;
   logic [DSR_W:0]       rem_ext;
   logic [DSR_W:0]       diff;
   logic                 last;

   // compare remainder with shifted divisor
   assign rem_ext = (DSR_W + 1)'(rem_ff);
   assign diff    = rem_ext - {1'b0, dsr_ff};
   assign ge      = ~diff[DSR_W];
   assign last    = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // step the divider
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      clip_in   = clip_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      quot_in   = quot_ff;
      if (div_start) begin
         active_in = 1'b1;
         clip_in   = 1'b0;
         cnt_in    = '0;
         rem_in    = div_num;
         dsr_in    = {div_den, {QUOT_W{1'b0}}};
         quot_in   = '0;
      end else if (active_ff) begin
         if (cnt_ff == '0 && ge) begin
            // quotient of 256 or more: saturate
            clip_in   = 1'b1;
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            if (ge) begin
               rem_in = NUM_W'(diff);
            end
            if (cnt_ff != '0) begin
               quot_in = {quot_ff[QUOT_W-2:0], ge};
            end
            dsr_in = dsr_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               active_in = 1'b0;
               done_in   = 1'b1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      clip_ff <= clip_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
   end

   assign div_status.done = done_ff;
   assign div_status.clip = clip_ff;
   assign div_quot        = quot_ff;

endmodule

// ===== sim/iq_cross_product_fm_demod_tb.sv =====
// ----------------------------------------------------------------------------
// iq_cross_product_fm_demod_tb
// Self-checking bench for the cross-product FM discriminator. Complex samples
// go in as single words; a behavioural discriminator inside the bench tracks
// the previous sample and predicts level, zero-magnitude and clip flags for
// each accepted word. Directed cases cover the sample extremes, zero magnitude
// and saturation in both directions. Random traffic is mostly slowly rotating
// phasors, with full-range noise and near-zero samples mixed in. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module iq_cross_product_fm_demod_tb
   import fmd_pkg::*;
();

   localparam int SW           = SAMPLE_WIDTH_DEF;
   localparam int RANDOM_WORDS = 1300;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS  = 10;
   localparam longint SAMPLE_MAX = (longint'(1) <<< (SW - 1)) - 1;
   localparam longint SAMPLE_MIN = -(longint'(1) <<< (SW - 1));

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               zero;
      logic               clip;
   } demod_word_type;

   logic                    clock           = 1'b0;
   logic                    reset           = 1'b1;
   logic                    req_valid       = 1'b0;
   logic                    req_stall;
   logic signed [SW-1:0]    req_sample_real = '0;
   logic signed [SW-1:0]    req_sample_imag = '0;
   logic                    rsp_valid;
   logic                    rsp_stall       = 1'b0;
   logic [LEVEL_W-1:0]      rsp_audio_level;
   logic                    rsp_zero_magnitude;
   logic                    rsp_clipped;

   // previous sample as the discriminator sees it
   logic signed [SW-1:0]    held_real = '0;
   logic signed [SW-1:0]    held_imag = '0;
   demod_word_type          pending_levels[$];
   demod_word_type          want;

   int  words_sent   = 0;
   int  words_seen   = 0;
   int  fail_count   = 0;
   int  idle_cycles  = 0;
   int  stall_left   = 0;
   bit  req_quiet    = 1'b1;
   bit  rsp_quiet    = 1'b1;

   iq_cross_product_fm_demod i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_real    (req_sample_real),
      .req_sample_imag    (req_sample_imag),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_audio_level    (rsp_audio_level),
      .rsp_zero_magnitude (rsp_zero_magnitude),
      .rsp_clipped        (rsp_clipped)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // level = |round(127*(C+M)/M)|, half away from zero, saturated at full scale
   function automatic demod_word_type discriminate(input logic signed [SW-1:0] re,
                                                   input logic signed [SW-1:0] im,
                                                   input logic signed [SW-1:0] pre,
                                                   input logic signed [SW-1:0] pim);
      longint          cross_term;
      longint          mag;
      longint          num;
      longint unsigned abs_num;
      longint unsigned den;
      longint unsigned quo;
      demod_word_type  w;
      cross_term = longint'(im) * longint'(pre) - longint'(re) * longint'(pim);
      mag        = longint'(re) * longint'(re) + longint'(im) * longint'(im);
      w.level = MID_LEVEL;
      w.zero  = 1'b0;
      w.clip  = 1'b0;
      if (mag == 0) begin
         w.zero = 1'b1;
      end else begin
         num     = 127 * (cross_term + mag);
         abs_num = (num < 0) ? -num : num;
         den     = mag;
         quo     = (2 * abs_num + den) / (2 * den);
         if (quo > longint'(MAX_LEVEL)) begin
            w.level = MAX_LEVEL;
            w.clip  = 1'b1;
         end else begin
            w.level = quo[LEVEL_W-1:0];
         end
      end
      return w;
   endfunction

   // mostly no gap, some short ones, a few long ones
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic longint clamp_sample(input longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
   endfunction

   // offer one sample, hold it until taken, then record its prediction
   task automatic send_sample(input int re, input int im);
      logic signed [SW-1:0] r_s;
      logic signed [SW-1:0] i_s;
      int                   gap;
      r_s = SW'(re);
      i_s = SW'(im);
      req_sample_real <= r_s;
      req_sample_imag <= i_s;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_levels.push_back(discriminate(r_s, i_s, held_real, held_imag));
      held_real = r_s;
      held_imag = i_s;
      words_sent++;
      gap = req_quiet ? 0 : gap_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_first_sample_after_reset();
      send_sample(1000, -2000);
   endtask

   task automatic test_extreme_samples();
      send_sample(32767, 32767);
      send_sample(-32768, -32768);
      send_sample(-32768, 32767);
      send_sample(32767, -32768);
      send_sample(0, -32768);
      send_sample(-32768, 0);
      send_sample(1, 0);
      send_sample(0, 1);
   endtask

   task automatic test_zero_magnitude();
      send_sample(0, 0);
      send_sample(0, 0);
      send_sample(-5, 3);
      send_sample(0, 0);
   endtask

   // a small current sample after each large one drives the ratio far out of range
   task automatic test_clipping();
      send_sample(32767, 0);
      send_sample(0, 1);
      send_sample(0, 32767);
      send_sample(1, 0);
      send_sample(-32768, -32768);
      send_sample(-1, 1);
   endtask

   // rotate a phasor by a small random angle each word
   task automatic test_phasor_run(input int len);
      logic signed [SW-1:0] seed_re;
      logic signed [SW-1:0] seed_im;
      longint               re;
      longint               im;
      longint               s;
      longint               c;
      longint               nr;
      longint               ni;
      int                   dev;
      int                   shift;
      seed_re = SW'($urandom);
      seed_im = SW'($urandom);
      shift   = $urandom_range(0, 14);
      re      = seed_re >>> shift;
      im      = seed_im >>> shift;
      dev     = $urandom_range(0, 16000);
      repeat (len) begin
         s  = longint'($urandom_range(0, 2 * dev)) - dev;
         c  = 32768 - (s * s) / 65536;
         nr = (re * c - im * s + 16384) >>> 15;
         ni = (im * c + re * s + 16384) >>> 15;
         re = clamp_sample(nr);
         im = clamp_sample(ni);
         send_sample(int'(re), int'(im));
      end
   endtask

   task automatic test_noise_run(input int len);
      repeat (len) send_sample($urandom, $urandom);
   endtask

   task automatic test_tiny_run(input int len);
      repeat (len) send_sample($urandom_range(0, 4) - 2, $urandom_range(0, 4) - 2);
   endtask

   task automatic test_random_traffic();
      int target;
      int pick;
      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         req_quiet = ($urandom_range(0, 9) == 0);
         rsp_quiet = ($urandom_range(0, 9) == 0);
         pick      = $urandom_range(0, 99);
         if (pick < 70)      test_phasor_run($urandom_range(10, 60));
         else if (pick < 90) test_noise_run($urandom_range(5, 20));
         else                test_tiny_run($urandom_range(3, 10));
      end
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left = stall_left - 1;
      end else if (!rsp_quiet && $urandom_range(0, 3) == 0) begin
         stall_left = gap_length();
         rsp_stall  <= (stall_left != 0);
         if (stall_left != 0) stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_levels.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $display("word %0d unexpected: level %0d zero %0b clip %0b",
                        words_seen, rsp_audio_level, rsp_zero_magnitude, rsp_clipped);
            fail_count++;
         end else begin
            want = pending_levels.pop_front();
            if (rsp_audio_level !== want.level || rsp_zero_magnitude !== want.zero ||
                rsp_clipped !== want.clip) begin
               if (fail_count < MAX_REPORTS)
                  $display("word %0d mismatch: expected level %0d zero %0b clip %0b,",
                           words_seen, want.level, want.zero, want.clip,
                           " got level %0d zero %0b clip %0b",
                           rsp_audio_level, rsp_zero_magnitude, rsp_clipped);
               fail_count++;
            end
         end
         words_seen++;
      end
   end

   // drop the run if neither channel moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("iq_cross_product_fm_demod_tb failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_first_sample_after_reset();
      test_extreme_samples();
      test_zero_magnitude();
      test_clipping();
      test_random_traffic();
      req_valid <= 1'b0;
      rsp_quiet = 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("iq_cross_product_fm_demod_tb passed");
      else
         $display("iq_cross_product_fm_demod_tb failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/fmd_pkg.sv
hw/rtl/fmd_mul.sv
hw/rtl/fmd_div.sv
hw/rtl/iq_cross_product_fm_demod.sv
sim/iq_cross_product_fm_demod_tb.sv
